// File: src/last_key_number_extractor_core_assert.svh
// Assertion helpers used by the readout.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef LAST_KEY_NUMBER_EXTRACTOR_CORE_ASSERT_SVH
`define LAST_KEY_NUMBER_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LKNE_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKNE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lkne_pkg.sv
package lkne_pkg;

  localparam int MAX_KEY_BYTES_DEF = 16;
  localparam int MAX_DIGITS_DEF    = 20;

  localparam int KEY_W      = 64;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_NO_DIGIT = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [LEN_W-1:0] KEY_LEN_RST = 5'd1;

  // digit store write control
  typedef struct packed {
    logic en;
    logic bank;
  } wr_ctl_t;

  // one result run, handed from the scanner to the readout
  typedef struct packed {
    logic [1:0] status;
    logic       ovf;
    logic       bank;
  } run_t;

endpackage

// File: src/lkne_cell.sv
// One key position: holds "key prefix up to here matched at the last byte".
module lkne_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] data_byte,
  input  logic [7:0] key_byte,
  input  logic       prev_q,
  output logic       hit,
  output logic       q
);
  import lkne_pkg::*;

  assign hit = prev_q && (data_byte == key_byte);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= hit;
    end
  end

endmodule

// File: src/lkne_scan.sv
// Key matcher chain plus digit capture control.
module lkne_scan #(
  parameter int MAX_KEY_BYTES = lkne_pkg::MAX_KEY_BYTES_DEF,
  parameter int MAX_DIGITS    = lkne_pkg::MAX_DIGITS_DEF,
  parameter int IW            = 5,
  parameter int CW            = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_stream,
  input  logic [lkne_pkg::KEY_W-1:0] key_low,
  input  logic [lkne_pkg::KEY_W-1:0] key_high,
  input  logic [lkne_pkg::LEN_W-1:0] key_length,
  output lkne_pkg::wr_ctl_t         wr_ctl,
  output logic [IW-1:0]             wr_addr,
  output logic [7:0]                wr_data,
  output logic                      start,
  output lkne_pkg::run_t            run,
  output logic [CW-1:0]             run_count
);
  import lkne_pkg::*;

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [2*KEY_W-1:0]       key_all;
  logic [MAX_KEY_BYTES-1:0] hit;
  logic [MAX_KEY_BYTES-1:0] q;

  logic          match_seen, match_seen_next;
  logic          capturing, capturing_next;
  logic [CW-1:0] digit_count, digit_count_next;
  logic          overflow_flag, overflow_flag_next;
  logic          search_stopped, search_stopped_next;
  logic          bank;

  logic             active, nz, is_digit, dig_in, room, match, shift, clear;
  logic [LEN_W-1:0] len_c, len_m1;

  assign key_all = {key_high, key_low};

  assign active   = take && !search_stopped;
  assign nz       = data_byte != 8'd0;
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign dig_in   = active && nz && capturing && is_digit;
  assign room     = digit_count < CW'(MAX_DIGITS);
  assign shift    = active && nz;
  assign clear    = take && end_of_stream;

  assign len_c  = (key_length > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_length;
  assign len_m1 = len_c - LEN_W'(1);
  assign match  = shift && (len_c != '0) && hit[len_m1[KIW-1:0]];

  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cell
    lkne_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .clear     (clear),
      .data_byte (data_byte),
      .key_byte  (key_all[8*i +: 8]),
      .prev_q    ((i == 0) ? 1'b1 : q[(i == 0) ? 0 : i-1]),
      .hit       (hit[i]),
      .q         (q[i])
    );
  end

  always_comb begin
    match_seen_next     = match_seen || match;
    search_stopped_next = search_stopped || (active && !nz);
    capturing_next      = capturing;
    digit_count_next    = digit_count;
    overflow_flag_next  = overflow_flag;
    if (active) begin
      if (!nz) begin
        capturing_next = 1'b0;
      end else if (capturing && !is_digit) begin
        capturing_next = 1'b0;
      end
    end
    if (dig_in) begin
      if (room) begin
        digit_count_next = digit_count + CW'(1);
      end else begin
        overflow_flag_next = 1'b1;
      end
    end
    // a key match restarts the capture, even on a digit just stored
    if (match) begin
      capturing_next     = 1'b1;
      digit_count_next   = '0;
      overflow_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen     <= 1'b0;
      capturing      <= 1'b0;
      digit_count    <= '0;
      overflow_flag  <= 1'b0;
      search_stopped <= 1'b0;
      bank           <= 1'b0;
    end else if (clear) begin
      match_seen     <= 1'b0;
      capturing      <= 1'b0;
      digit_count    <= '0;
      overflow_flag  <= 1'b0;
      search_stopped <= 1'b0;
      bank           <= !bank;
    end else if (take) begin
      match_seen     <= match_seen_next;
      capturing      <= capturing_next;
      digit_count    <= digit_count_next;
      overflow_flag  <= overflow_flag_next;
      search_stopped <= search_stopped_next;
    end
  end

  assign wr_ctl.en   = dig_in && room;
  assign wr_ctl.bank = bank;
  assign wr_addr     = digit_count[IW-1:0];
  assign wr_data     = data_byte;

  assign start     = clear;
  assign run_count = digit_count_next;
  assign run.ovf   = overflow_flag_next;
  assign run.bank  = bank;
  assign run.status = !match_seen_next         ? ST_ABSENT :
                      (digit_count_next == '0) ? ST_NO_DIGIT : ST_FOUND;

endmodule

// File: src/lkne_readout.sv
`include "last_key_number_extractor_core_assert.svh"

// Two-bank digit store and the result run sequencer.
module lkne_readout #(
  parameter int MAX_DIGITS = lkne_pkg::MAX_DIGITS_DEF,
  parameter int IW         = 5,
  parameter int CW         = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  lkne_pkg::wr_ctl_t wr_ctl,
  input  logic [IW-1:0]     wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              start,
  input  lkne_pkg::run_t    run,
  input  logic [CW-1:0]     run_count,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [7:0]        digit_char,
  output logic              digits_overflowed,
  output logic              run_end
);
  import lkne_pkg::*;

  logic [7:0] mem [2][MAX_DIGITS];
  logic [7:0] mem_q;

  logic          rd_active;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] rd_count;
  logic [1:0]    rd_status;
  logic          rd_ovf;
  logic          rd_bank;
  logic          rd_last;

  logic       s1_valid;
  logic [1:0] s1_status;
  logic       s1_ovf;
  logic       s1_last;

  logic issue, s1_move;

  assign busy    = rd_active;
  assign s1_move = s1_valid && (!out_valid || !out_stall);
  assign issue   = rd_active && (!s1_valid || s1_move);
  assign rd_last = (rd_status != ST_FOUND) || ((CW'(rd_idx) + CW'(1)) == rd_count);

  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      mem[wr_ctl.bank][wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q <= mem[rd_bank][rd_idx];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        rd_active <= 1'b1;
      end else if (issue && rd_last) begin
        rd_active <= 1'b0;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      rd_idx    <= '0;
      rd_count  <= run_count;
      rd_status <= run.status;
      rd_ovf    <= run.ovf;
      rd_bank   <= run.bank;
    end else if (issue) begin
      rd_idx <= rd_idx + IW'(1);
    end
    if (issue) begin
      s1_status <= rd_status;
      s1_ovf    <= (rd_status == ST_FOUND) && rd_ovf;
      s1_last   <= rd_last;
    end
    if (s1_move) begin
      status            <= s1_status;
      digit_char        <= (s1_status == ST_FOUND) ? mem_q : 8'd0;
      digits_overflowed <= s1_ovf;
      run_end           <= s1_last;
    end
  end

  `LKNE_CHECK(run_no_overlap, start, !rd_active, "run started while another is issuing")
  `LKNE_CHECK_NEXT(run_starts, start, rd_active, "run start not registered")
  `LKNE_CHECK(read_in_range, issue && rd_status == ST_FOUND, CW'(rd_idx) < rd_count, "digit read past count")
  `LKNE_CHECK(found_has_digits, start && run.status == ST_FOUND, run_count != '0, "found run with no digits")

endmodule

// File: src/last_key_number_extractor_core.sv
// Once the end_of_stream item is taken, results pass a read stage and the output register.
// Takes a byte per cycle unless in_stall; emits one result item per cycle unless out_stall.
// An end_of_stream item is held off while the previous run is still being read out.
// Reset (rst, synchronous): clears the matcher chain, capture state, key registers
// (key_length to 1) and the result pipeline; the digit store is not cleared.
module last_key_number_extractor_core #(
  parameter int MAX_KEY_BYTES = lkne_pkg::MAX_KEY_BYTES_DEF,
  parameter int MAX_DIGITS    = lkne_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // byte stream in
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_stream,
  // result items out
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [7:0]                      digit_char,
  output logic                            digits_overflowed,
  output logic                            run_end,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lkne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lkne_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lkne_pkg::*;

  // digit store index bits, and count bits (count can equal MAX_DIGITS)
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [KEY_W-1:0] key_low_bytes;
  logic [KEY_W-1:0] key_high_bytes;
  logic [LEN_W-1:0] key_length;

  logic          take;
  logic          busy;
  wr_ctl_t       wr_ctl;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          start;
  run_t          run;
  logic [CW-1:0] run_count;

  // Registers are always writable; the user must change the key only while idle, the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_bytes  <= '0;
      key_high_bytes <= '0;
      key_length     <= KEY_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_bytes  <= cfg_data;
        REG_KEY_HIGH: key_high_bytes <= cfg_data;
        REG_KEY_LEN:  key_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Plain bytes always flow. The end-of-stream item closes a run, and the
  // readout holds one run at a time, so only that item waits on busy.
  assign in_stall = end_of_stream && busy;
  assign take     = in_valid && !in_stall;

  // Matcher: one cell per key byte. Cell i carries "key bytes 0..i matched,
  // ending at the last byte" and hands it to cell i+1 on each nonzero byte
  // until a zero byte, so cell key_length-1 flags a full (possibly overlapping) match.
  // Digits after a match are written into the current bank of the store.
  lkne_scan #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .MAX_DIGITS    (MAX_DIGITS),
    .IW            (IW),
    .CW            (CW)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .key_low       (key_low_bytes),
    .key_high      (key_high_bytes),
    .key_length    (key_length),
    .wr_ctl        (wr_ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .start         (start),
    .run           (run),
    .run_count     (run_count)
  );

  // Readout: banks swap at each end of stream, so the next stream captures
  // into the other bank while this run drains through a read stage and the
  // output register.
  lkne_readout #(
    .MAX_DIGITS (MAX_DIGITS),
    .IW         (IW),
    .CW         (CW)
  ) u_readout (
    .clk               (clk),
    .rst               (rst),
    .wr_ctl            (wr_ctl),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .start             (start),
    .run               (run),
    .run_count         (run_count),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .digit_char        (digit_char),
    .digits_overflowed (digits_overflowed),
    .run_end           (run_end)
  );

endmodule
